/* rtl/core/nulink_pkg.sv */
package nulink_pkg;

  localparam int NODE_W = 8;
  localparam int COORD_W = 16;
  localparam int DIST_W = 34;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_LINK = 2'd1;
  localparam logic [1:0] CMD_TOGGLE = 2'd2;

  localparam logic [2:0] ACT_WRITTEN = 3'd0;
  localparam logic [2:0] ACT_LINKED = 3'd1;
  localparam logic [2:0] ACT_UNLINKED = 3'd2;
  localparam logic [2:0] ACT_NO_PARTNER = 3'd3;
  localparam logic [2:0] ACT_ALREADY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINK = 2'd2;

  localparam logic [DIST_W-1:0] SEARCH_LIMIT_RST = 34'd16777216;
  localparam logic [DIST_W-1:0] MIN_DIST_RST = 34'd17;
  localparam logic [DIST_W-1:0] MAX_LINK_RST = 34'd16777216;

  typedef struct packed {
    logic [1:0] command;
    logic [NODE_W-1:0] node_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [2:0] action;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [DIST_W-1:0] dist_sq;
  } out_word_t;

endpackage

/* rtl/core/nearest_unlinked_pair_linker.sv */
// Channel | Dir | Handshake               | Word
// in_     | in  | in_valid / in_ready     | in_word_t (command, node, position)
// out_    | out | out_valid / out_ready   | out_word_t (action, nodes, dist_sq)
// cfg_    | in  | cfg_we                  | cfg_index, cfg_wdata (34 bits)
//
// One word at a time. Write and rejected words go straight to the output state;
// other requests look up the node first, and unlink clears both map entries.
// A link request scans the position and partner memories, one node per cycle
// through the distance pipe, then drains that pipe before the decision.
// After reset a clearing pass empties the partner map; in_ready stays low
// meanwhile. A stalled result holds in the output register.
module nearest_unlinked_pair_linker
  import nulink_pkg::*;
#(
  parameter int NODE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int POS_W = 3 * COORD_W;
  localparam int PM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_LOOKUP = 4'd2;
  localparam logic [3:0] ST_UNLINK = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_DRAIN = 4'd5;
  localparam logic [3:0] ST_DECIDE = 4'd6;
  localparam logic [3:0] ST_LINK = 4'd7;
  localparam logic [3:0] ST_OUT = 4'd8;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  logic [3:0] state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [IDX_W-1:0] nidx_r, nidx_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [2:0] act_r, act_nxt;
  logic [IDX_W-1:0] sec_r, sec_nxt;
  logic [DIST_W-1:0] dsq_r, dsq_nxt;
  logic [POS_W-1:0] own_r, own_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic found_r, found_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic [DIST_W-1:0] search_lim_r, min_r, max_r;

  logic [POS_W-1:0] pos_mem [NODE_COUNT];
  logic [PM_W-1:0] pm_mem [NODE_COUNT];
  logic [POS_W-1:0] pos_rd_r;
  logic [PM_W-1:0] pm_rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic pos_we;
  logic pm_we;
  logic [IDX_W-1:0] pm_waddr;
  logic [PM_W-1:0] pm_wdata;
  logic in_range;

  logic rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic a_v_r, a_lk_r;
  logic [IDX_W-1:0] a_idx_r;
  logic [2*COORD_W-1:0] sqx_r, sqy_r, sqz_r;
  logic b_v_r, b_lk_r;
  logic [IDX_W-1:0] b_idx_r;
  logic [DIST_W-1:0] d2_r;

  logic [COORD_W-1:0] mx, my, mz;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign in_range = 32'(in_data.node_index) < 32'(NODE_COUNT);
  assign rd_addr = (state_r == ST_IDLE) ? IDX_W'(in_data.node_index) : cnt_r;
  assign pos_we = (state_r == ST_IDLE) && in_valid && (in_data.command == CMD_WRITE)
                  && in_range;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[IDX_W'(in_data.node_index)] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    pos_rd_r <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    pm_rd_r <= pm_mem[rd_addr];
  end

  // distance pipe: read, square, sum; compare in the sequencer
  assign mx = abs_diff(own_r[3*COORD_W-1:2*COORD_W], pos_rd_r[3*COORD_W-1:2*COORD_W]);
  assign my = abs_diff(own_r[2*COORD_W-1:COORD_W], pos_rd_r[2*COORD_W-1:COORD_W]);
  assign mz = abs_diff(own_r[COORD_W-1:0], pos_rd_r[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    a_idx_r <= rd_idx_r;
    a_lk_r <= pm_rd_r[IDX_W];
    sqx_r <= mx * mx;
    sqy_r <= my * my;
    sqz_r <= mz * mz;
    b_idx_r <= a_idx_r;
    b_lk_r <= a_lk_r;
    d2_r <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_SCAN);
      a_v_r <= rd_v_r;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_lim_r <= SEARCH_LIMIT_RST;
      min_r <= MIN_DIST_RST;
      max_r <= MAX_LINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_LIMIT: search_lim_r <= cfg_wdata;
        CFG_MIN_DIST: min_r <= cfg_wdata;
        CFG_MAX_LINK: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd_nxt = cmd_r;
    nidx_nxt = nidx_r;
    node_nxt = node_r;
    act_nxt = act_r;
    sec_nxt = sec_r;
    dsq_nxt = dsq_r;
    own_nxt = own_r;
    best_nxt = best_r;
    best_idx_nxt = best_idx_r;
    found_nxt = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    pm_we = 1'b0;
    pm_waddr = cnt_r;
    pm_wdata = '0;

    // compare stage, lowest index wins on a tie
    if (b_v_r && !b_lk_r && (d2_r < best_r) && (d2_r > min_r)) begin
      best_nxt = d2_r;
      best_idx_nxt = b_idx_r;
      found_nxt = 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        pm_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.command;
          node_nxt = in_data.node_index;
          nidx_nxt = IDX_W'(in_data.node_index);
          sec_nxt = '0;
          dsq_nxt = '0;
          act_nxt = ACT_NO_PARTNER;
          state_nxt = ST_OUT;
          case (in_data.command)
            CMD_WRITE: act_nxt = ACT_WRITTEN;
            CMD_LINK, CMD_TOGGLE: begin
              if (in_range) begin
                state_nxt = ST_LOOKUP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        own_nxt = pos_rd_r;
        if (pm_rd_r[IDX_W]) begin
          if (cmd_r == CMD_LINK) begin
            act_nxt = ACT_ALREADY;
            state_nxt = ST_OUT;
          end else begin
            pm_we = 1'b1;
            pm_waddr = nidx_r;
            sec_nxt = pm_rd_r[IDX_W-1:0];
            act_nxt = ACT_UNLINKED;
            state_nxt = ST_UNLINK;
          end
        end else begin
          best_nxt = search_lim_r;
          best_idx_nxt = '0;
          found_nxt = 1'b0;
          cnt_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_UNLINK: begin
        pm_we = 1'b1;
        pm_waddr = sec_r;
        state_nxt = ST_OUT;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(rd_v_r || a_v_r || b_v_r)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (found_r && (best_r < max_r)) begin
          pm_we = 1'b1;
          pm_waddr = nidx_r;
          pm_wdata = {1'b1, best_idx_r};
          act_nxt = ACT_LINKED;
          sec_nxt = best_idx_r;
          dsq_nxt = best_r;
          state_nxt = ST_LINK;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_LINK: begin
        pm_we = 1'b1;
        pm_waddr = sec_r;
        pm_wdata = {1'b1, nidx_r};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.action = act_r;
          out_data_nxt.first_node = node_r;
          out_data_nxt.second_node = NODE_W'(sec_r);
          out_data_nxt.dist_sq = dsq_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    nidx_r <= nidx_nxt;
    node_r <= node_nxt;
    act_r <= act_nxt;
    sec_r <= sec_nxt;
    dsq_r <= dsq_nxt;
    own_r <= own_nxt;
    best_r <= best_nxt;
    best_idx_r <= best_idx_nxt;
    found_r <= found_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/nulink_checker.sv */
module nulink_checker
  import nulink_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block active straight after reset");

  a_dist_only_on_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.action == ACT_LINKED || out_data.dist_sq == '0))
    else $error("distance reported without a new link");

  a_partner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_WRITTEN || out_data.action == ACT_NO_PARTNER
                  || out_data.action == ACT_ALREADY) |-> out_data.second_node == '0)
    else $error("partner reported without a link change");

endmodule

bind nearest_unlinked_pair_linker nulink_checker u_nulink_checker (.*);
